[hdl/pgray_pkg.sv]
// Package for the pixel grayscale converter: pixel format codes, channel type,
// register map and default weight precision. No dependencies.
package pgray_pkg;

  // Fraction bits of the fixed-point luma weights
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  // Configuration register map (word index into the APB space)
  localparam logic REG_PIXEL_FORMAT = 1'b0;

  typedef enum logic [1:0] {
    FMT_BGR32  = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_RGB555 = 2'd2,
    FMT_RSVD   = 2'd3
  } pix_fmt_e;

  // One pixel widened to 8 bits a channel
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

endpackage

[hdl/pgray_unpack.sv]
// Channel extraction: splits a pixel word into red, green and blue, widened
// to 8 bits. Depends on pgray_pkg.
module pgray_unpack (
  input  pgray_pkg::pix_fmt_e fmt_i,
  input  logic [31:0]         pixel_i,
  output pgray_pkg::rgb_t     rgb_o
);
  import pgray_pkg::*;

  always_comb begin
    case (fmt_i)
      FMT_BGR32: begin
        rgb_o.r = pixel_i[23:16];
        rgb_o.g = pixel_i[15:8];
        rgb_o.b = pixel_i[7:0];
      end
      FMT_RGB565: begin
        rgb_o.r = {pixel_i[15:11], 3'b000};
        rgb_o.g = {pixel_i[10:5], 2'b00};
        rgb_o.b = {pixel_i[4:0], 3'b000};
      end
      FMT_RGB555: begin
        rgb_o.r = {pixel_i[14:10], 3'b000};
        rgb_o.g = {pixel_i[9:5], 3'b000};
        rgb_o.b = {pixel_i[4:0], 3'b000};
      end
      default: begin
        rgb_o = '0;
      end
    endcase
  end

endmodule

[hdl/pgray_luma.sv]
// Luma computation: weighted sum of the three channels with fixed-point
// weights that sum to exactly one. Depends on pgray_pkg.
module pgray_luma #(
  parameter int WEIGHT_FRAC_BITS = pgray_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  pgray_pkg::rgb_t rgb_i,
  output logic [7:0]      gray_o
);
  import pgray_pkg::*;

  localparam int PW = WEIGHT_FRAC_BITS + 8;
  localparam longint unsigned WtOne = 64'd1 << WEIGHT_FRAC_BITS;
  localparam longint unsigned WtRed = (64'd299 * WtOne + 64'd500) / 64'd1000;
  localparam longint unsigned WtGreen = (64'd587 * WtOne + 64'd500) / 64'd1000;
  localparam longint unsigned WtBlue = WtOne - WtRed - WtGreen;

  logic [PW-1:0] prod_r, prod_g, prod_b;
  logic [PW+1:0] acc;

  assign prod_r = PW'(WtRed) * PW'(rgb_i.r);
  assign prod_g = PW'(WtGreen) * PW'(rgb_i.g);
  assign prod_b = PW'(WtBlue) * PW'(rgb_i.b);

  // Weights sum to one, so the total stays below 256 << frac bits
  assign acc = {2'b00, prod_r} + {2'b00, prod_g} + {2'b00, prod_b};
  assign gray_o = acc[WEIGHT_FRAC_BITS +: 8];

endmodule

[hdl/pgray_pack.sv]
// Repacking: writes the gray value back into every channel of the selected
// format; a reserved code passes the pixel through. Depends on pgray_pkg.
module pgray_pack (
  input  pgray_pkg::pix_fmt_e fmt_i,
  input  logic [31:0]         pixel_i,
  input  logic [7:0]          gray_i,
  output logic [31:0]         pixel_o,
  output logic [7:0]          gray_o
);
  import pgray_pkg::*;

  always_comb begin
    gray_o = gray_i;
    case (fmt_i)
      FMT_BGR32: begin
        pixel_o = {pixel_i[31:24], gray_i, gray_i, gray_i};
      end
      FMT_RGB565: begin
        pixel_o = {16'h0000, gray_i[7:3], gray_i[7:2], gray_i[7:3]};
      end
      FMT_RGB555: begin
        pixel_o = {17'd0, gray_i[7:3], gray_i[7:3], gray_i[7:3]};
      end
      default: begin
        // Reserved code: pass the pixel through, report no gray
        pixel_o = pixel_i;
        gray_o  = '0;
      end
    endcase
  end

endmodule

[hdl/pixel_grayscale_converter.sv]
// Top level of the pixel grayscale converter: APB register, input register,
// result register. Depends on pgray_pkg, pgray_unpack, pgray_luma, pgray_pack.

// Takes one pixel a cycle and returns its gray version in the same format
// after start is taken: the item passes the input register, then the
// result register, with the unpack, luma and repack logic between them. busy
// stays low, so a new item may follow in every cycle. Each result shows on
// pixel_out_o and gray_level_o for the single cycle in which done_o is high;
// the receiver cannot stall. Write pixel_format (byte address 0) only while
// no item is in flight.
module pixel_grayscale_converter #(
  parameter int WEIGHT_FRAC_BITS = pgray_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Item input
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pixel_in_i,
  // Result output
  output logic        done_o,
  output logic [31:0] pixel_out_o,
  output logic [7:0]  gray_level_o
);
  import pgray_pkg::*;

  pix_fmt_e    pixel_format_q, pixel_format_d;
  logic        in_valid_q;
  logic [31:0] pixel_q;
  pix_fmt_e    fmt_q;
  logic        out_valid_q;
  logic [31:0] pixel_out_q, pixel_out_d;
  logic [7:0]  gray_q, gray_d;
  rgb_t        rgb;
  logic [7:0]  luma;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PIXEL_FORMAT);

  assign pixel_format_d = cfg_wr ? pix_fmt_e'(pwdata[1:0]) : pixel_format_q;
  assign prdata = (paddr[2] == REG_PIXEL_FORMAT) ? {30'd0, pixel_format_q} : 32'd0;

  pgray_unpack u_unpack (
    .fmt_i   (fmt_q),
    .pixel_i (pixel_q),
    .rgb_o   (rgb)
  );

  pgray_luma #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_luma (
    .rgb_i  (rgb),
    .gray_o (luma)
  );

  pgray_pack u_pack (
    .fmt_i   (fmt_q),
    .pixel_i (pixel_q),
    .gray_i  (luma),
    .pixel_o (pixel_out_d),
    .gray_o  (gray_d)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= FMT_BGR32;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      pixel_format_q <= pixel_format_d;
      in_valid_q     <= start && !busy;
      out_valid_q    <= in_valid_q;
    end
  end

  // Payload: capture the item with its format, then the result
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      pixel_q <= pixel_in_i;
      fmt_q   <= pixel_format_q;
    end
    if (in_valid_q) begin
      pixel_out_q <= pixel_out_d;
      gray_q      <= gray_d;
    end
  end

  assign done_o       = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign gray_level_o = gray_q;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted item produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid_q))
    else $error("result without an accepted item");

  a_reserved_no_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pixel_format_q == FMT_RSVD) |-> gray_level_o == 8'd0)
    else $error("reserved format reported a gray level");

  a_short_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (pixel_format_q == FMT_RGB565 || pixel_format_q == FMT_RGB555))
      |-> pixel_out_o[31:16] == 16'h0000)
    else $error("16-bit format left upper half set");

  a_bgr_channels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pixel_format_q == FMT_BGR32)
      |-> (pixel_out_o[7:0] == gray_level_o && pixel_out_o[15:8] == gray_level_o
           && pixel_out_o[23:16] == gray_level_o))
    else $error("32-bit format channels differ from gray level");
`endif

endmodule
